/* rtl/chd_pkg.sv */
package chd_pkg;

  localparam int MAX_SYMBOLS_DEF   = 288;
  localparam int MAX_CODE_BITS_DEF = 15;
  localparam int LEN_SLOTS         = 16;
  localparam int LIT_SYMBOLS       = 288;
  localparam int DIST_SYMBOLS      = 32;
  localparam int SYM_W             = 9;

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_FIXLIT   = 2'd1,
    CMD_FIXDIST  = 2'd2,
    CMD_DECODE   = 2'd3
  } chd_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_COUNT,
    S_FIRST,
    S_SORT,
    S_DEC
  } chd_state_t;

  typedef struct packed {
    chd_cmd_t   cmd;
    logic [8:0] symbol_index;
    logic [3:0] code_length;
    logic       last_length;
    logic       bit_in;
  } chd_in_t;

  typedef struct packed {
    logic [8:0] symbol;
    logic [3:0] code_bits;
    logic       error;
  } chd_out_t;

  typedef struct packed {
    logic hit;
    logic idx_ok;
  } chd_match_t;

  // fixed deflate code lengths
  function automatic logic [3:0] fixed_len(input logic [8:0] sym, input logic lit);
    logic [3:0] l;
    if (!lit) begin
      l = 4'd5;
    end else if (sym <= 9'd143 || sym >= 9'd280) begin
      l = 4'd8;
    end else if (sym <= 9'd255) begin
      l = 4'd9;
    end else begin
      l = 4'd7;
    end
    return l;
  endfunction

endpackage

/* rtl/chd_match.sv */
module chd_match #(
  parameter int MAX_SYMBOLS = chd_pkg::MAX_SYMBOLS_DEF,
  parameter int CNT_W       = $clog2(MAX_SYMBOLS + 1)
) (
  input  logic [15:0]          acc,
  input  logic                 len_ok,
  input  logic [15:0]          first_code,
  input  logic [CNT_W-1:0]     count,
  input  logic [CNT_W-1:0]     first_index,
  output chd_pkg::chd_match_t  match,
  output logic [CNT_W:0]       k
);
  import chd_pkg::*;

  logic [15:0] off;

  // offset only matters on a hit, where it stays below count
  assign off = acc - first_code;
  assign k   = {1'b0, first_index} + off[CNT_W:0];

  always_comb begin
    match.hit    = len_ok && (acc >= first_code) && (off < 16'(count));
    match.idx_ok = (32'(k) < 32'(MAX_SYMBOLS));
  end

endmodule

/* rtl/canonical_huffman_decoder.sv */
// canonical huffman decoder for deflate style prefix codes
// input channel in_*: one request per accepted item (in_valid high, in_stall low)
//   load length: writes one code length; with last_length set the code is built
//   fixed literal / fixed distance: loads the fixed lengths and builds the code
//   decode: shifts one stream bit in, msb of the code first
// output channel out_*: one result for a decode bit that completes a code, that
//   reaches the code bit limit without a match, or that arrives with no table
// a decode request that yields a result does the count compare and the sorted
//   symbol memory read as it is accepted, then loads the output register in
//   S_DEC once that register is free; a bit that completes nothing ends there
// a build makes two sweeps through the length memory (count, then sort), one
//   symbol per cycle, with 14 first-code steps between them; fixed tables
//   first fill the length memory, one symbol per cycle
// in_stall is high while a request is being worked on
// reset clears the partial code and marks no table; length and sorted memories
//   are not cleared
// a stalled result holds in the output register; the decoder waits for it
module canonical_huffman_decoder #(
  parameter int MAX_SYMBOLS   = chd_pkg::MAX_SYMBOLS_DEF,
  parameter int MAX_CODE_BITS = chd_pkg::MAX_CODE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  chd_pkg::chd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output chd_pkg::chd_out_t out_data
);
  import chd_pkg::*;

  localparam int SYM_AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
  localparam logic [CNT_W-1:0] N_LIT  =
    CNT_W'((LIT_SYMBOLS < MAX_SYMBOLS) ? LIT_SYMBOLS : MAX_SYMBOLS);
  localparam logic [CNT_W-1:0] N_DIST =
    CNT_W'((DIST_SYMBOLS < MAX_SYMBOLS) ? DIST_SYMBOLS : MAX_SYMBOLS);

  chd_state_t state_r, state_nxt;

  logic [3:0]       len_mem [MAX_SYMBOLS];
  logic [SYM_W-1:0] srt_mem [MAX_SYMBOLS];
  logic [3:0]       len_rd_r;
  logic [SYM_W-1:0] srt_rd_r;

  logic [CNT_W-1:0] cnt_r [LEN_SLOTS];
  logic [15:0]      fc_r  [LEN_SLOTS];
  logic [CNT_W-1:0] fi_r  [LEN_SLOTS];
  logic [CNT_W-1:0] ns_r  [LEN_SLOTS];

  logic [15:0]       acc_r;
  logic [4:0]        bits_r;
  logic              ready_r;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  sc_r;
  logic              rdv_r;
  logic [SYM_AW-1:0] rd_sym_r;
  logic [3:0]        l_r;
  logic              lit_r;
  logic              pend_sym_r;
  logic              pend_err_r;
  logic [3:0]        pend_bits_r;
  logic              out_valid_r;
  chd_out_t          out_data_r;

  logic        in_acc, out_free, sweep_rd, fill_last, sweep_done, idx_in;
  logic [15:0] acc_n;
  logic [4:0]  bits_n;
  logic [3:0]  li;
  logic [3:0]  lm1;
  logic        nomatch;
  logic [CNT_W:0] k;
  chd_match_t  mt;
  logic [CNT_W:0] n_load;
  logic [CNT_W-1:0] k_sort;

  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign sweep_rd   = (state_r == S_COUNT || state_r == S_SORT) && (sc_r < n_r);
  assign fill_last  = (sc_r == n_r - CNT_W'(1));
  assign sweep_done = (sc_r == n_r) && !rdv_r;
  assign idx_in     = (10'(in_data.symbol_index) < 10'(MAX_SYMBOLS));
  assign n_load     = (CNT_W+1)'(in_data.symbol_index) + (CNT_W+1)'(1);
  assign lm1        = l_r - 4'd1;
  assign k_sort     = ns_r[len_rd_r];

  assign acc_n   = {acc_r[14:0], in_data.bit_in};
  assign bits_n  = bits_r + 5'd1;
  assign li      = bits_n[3:0];
  assign nomatch = (bits_n >= 5'(MAX_CODE_BITS));

  chd_match #(.MAX_SYMBOLS(MAX_SYMBOLS), .CNT_W(CNT_W)) u_match (
    .acc         (acc_n),
    .len_ok      (bits_n < 5'(LEN_SLOTS)),
    .first_code  (fc_r[li]),
    .count       (cnt_r[li]),
    .first_index (fi_r[li]),
    .match       (mt),
    .k           (k)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data.cmd)
            CMD_LOAD:    if (in_data.last_length) state_nxt = S_COUNT;
            CMD_FIXLIT,
            CMD_FIXDIST: state_nxt = S_FILL;
            CMD_DECODE: begin
              if (!ready_r || mt.hit || nomatch) state_nxt = S_DEC;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_FILL:  if (fill_last) state_nxt = S_COUNT;
      S_COUNT: if (sweep_done) state_nxt = S_FIRST;
      S_FIRST: if (l_r == 4'd15) state_nxt = S_SORT;
      S_SORT:  if (sweep_done) state_nxt = S_IDLE;
      S_DEC:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = (state_r != S_IDLE);
    out_valid = out_valid_r;
    out_data  = out_data_r;
  end

  // length memory
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc && in_data.cmd == CMD_LOAD && idx_in) begin
      len_mem[in_data.symbol_index[SYM_AW-1:0]] <= in_data.code_length;
    end else if (state_r == S_FILL) begin
      len_mem[sc_r[SYM_AW-1:0]] <= fixed_len(9'(sc_r), lit_r);
    end
    if (sweep_rd) len_rd_r <= len_mem[sc_r[SYM_AW-1:0]];
  end

  // sorted symbol memory
  always_ff @(posedge clk) begin
    if (state_r == S_SORT && rdv_r && len_rd_r != 4'd0 &&
        32'(k_sort) < 32'(MAX_SYMBOLS)) begin
      srt_mem[k_sort[SYM_AW-1:0]] <= SYM_W'(rd_sym_r);
    end
    if (state_r == S_IDLE && in_acc && in_data.cmd == CMD_DECODE && mt.idx_ok) begin
      srt_rd_r <= srt_mem[k[SYM_AW-1:0]];
    end
  end

  // build tables and sweep control
  always_ff @(posedge clk) begin
    rdv_r    <= sweep_rd;
    rd_sym_r <= sc_r[SYM_AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        sc_r <= '0;
        if (in_acc) begin
          unique case (in_data.cmd)
            CMD_LOAD: begin
              n_r <= (n_load > (CNT_W+1)'(MAX_SYMBOLS)) ? CNT_W'(MAX_SYMBOLS)
                                                         : n_load[CNT_W-1:0];
              // counts of the code in use stay until a build starts
              if (in_data.last_length) begin
                for (int i = 0; i < LEN_SLOTS; i++) cnt_r[i] <= '0;
              end
            end
            CMD_FIXLIT: begin
              n_r   <= N_LIT;
              lit_r <= 1'b1;
            end
            CMD_FIXDIST: begin
              n_r   <= N_DIST;
              lit_r <= 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        sc_r <= fill_last ? '0 : sc_r + CNT_W'(1);
        for (int i = 0; i < LEN_SLOTS; i++) cnt_r[i] <= '0;
      end
      S_COUNT: begin
        if (sc_r < n_r) sc_r <= sc_r + CNT_W'(1);
        if (rdv_r && len_rd_r != 4'd0) cnt_r[len_rd_r] <= cnt_r[len_rd_r] + CNT_W'(1);
        if (sweep_done) begin
          l_r      <= 4'd2;
          fc_r[0]  <= '0;
          fc_r[1]  <= '0;
          fi_r[0]  <= '0;
          fi_r[1]  <= '0;
          ns_r[0]  <= '0;
          ns_r[1]  <= '0;
        end
      end
      S_FIRST: begin
        fc_r[l_r] <= 16'(({1'b0, fc_r[lm1]} + 17'(cnt_r[lm1])) << 1);
        fi_r[l_r] <= fi_r[lm1] + cnt_r[lm1];
        ns_r[l_r] <= fi_r[lm1] + cnt_r[lm1];
        l_r       <= l_r + 4'd1;
        sc_r      <= '0;
      end
      S_SORT: begin
        if (sc_r < n_r) sc_r <= sc_r + CNT_W'(1);
        if (rdv_r && len_rd_r != 4'd0) ns_r[len_rd_r] <= k_sort + CNT_W'(1);
      end
      S_DEC: ;
      default: ;
    endcase
  end

  // control state, partial code and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      bits_r      <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DEC && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_IDLE && in_acc) begin
        if (in_data.cmd != CMD_DECODE) begin
          acc_r  <= '0;
          bits_r <= '0;
        end else if (ready_r) begin
          if (mt.hit || nomatch) begin
            acc_r  <= '0;
            bits_r <= '0;
          end else begin
            acc_r  <= acc_n;
            bits_r <= bits_n;
          end
        end
      end
      if (state_r == S_SORT && sweep_done) ready_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc && in_data.cmd == CMD_DECODE) begin
      if (!ready_r) begin
        pend_sym_r  <= 1'b0;
        pend_err_r  <= 1'b1;
        pend_bits_r <= 4'd0;
      end else if (mt.hit) begin
        pend_sym_r  <= mt.idx_ok;
        pend_err_r  <= 1'b0;
        pend_bits_r <= li;
      end else begin
        pend_sym_r  <= 1'b0;
        pend_err_r  <= 1'b1;
        pend_bits_r <= 4'(MAX_CODE_BITS);
      end
    end
    if (state_r == S_DEC && out_free) begin
      out_data_r.symbol    <= pend_sym_r ? srt_rd_r : '0;
      out_data_r.code_bits <= pend_bits_r;
      out_data_r.error     <= pend_err_r;
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input accepted while busy");

  a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r < 5'(MAX_CODE_BITS))
    else $error("partial code exceeds code bit limit");

  a_no_table_err: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.cmd == CMD_DECODE && !ready_r) |=> (state_r == S_DEC))
    else $error("decode without table gave no result");

  a_build_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SORT && sweep_done) |=> ready_r)
    else $error("table not marked ready after build");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");

endmodule

/* tb/canonical_huffman_decoder_test.sv */
module canonical_huffman_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import chd_pkg::*;

  localparam int NUM_SYMS = MAX_SYMBOLS_DEF;
  localparam int CODE_MAX = MAX_CODE_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 300;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  chd_in_t in_data;
  logic out_valid;
  logic out_stall;
  chd_out_t out_data;

  canonical_huffman_decoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // shadow of the decoder's code tables
  logic [3:0] len_of_sym [NUM_SYMS];
  int unsigned len_count [LEN_SLOTS];
  int unsigned first_code [LEN_SLOTS];
  int unsigned first_slot [LEN_SLOTS];
  logic [8:0] sym_by_code [NUM_SYMS];
  int unsigned code_acc;
  int unsigned acc_bits;
  bit have_table;

  chd_out_t symbol_q[$];
  int fails;
  int reqs_sent;
  int results_seen;
  int tables_built;
  int error_results;
  bit calm;
  bit hold_req;
  int idle_cycles;

  function automatic chd_in_t mk_req(chd_cmd_t c, int idx, int len, bit last, bit b);
    chd_in_t r;
    r.cmd = c;
    r.symbol_index = idx[8:0];
    r.code_length = len[3:0];
    r.last_length = last;
    r.bit_in = b;
    return r;
  endfunction

  function automatic chd_out_t mk_res(int sym, int nbits, bit err);
    chd_out_t o;
    o.symbol = sym[8:0];
    o.code_bits = nbits[3:0];
    o.error = err;
    return o;
  endfunction

  function automatic void build_canonical(int unsigned n);
    int unsigned next_slot [LEN_SLOTS];
    int unsigned k;
    if (n > NUM_SYMS) n = NUM_SYMS;
    for (int l = 0; l < LEN_SLOTS; l++) len_count[l] = 0;
    for (int s = 0; s < n; s++) begin
      if (len_of_sym[s] != 0) len_count[len_of_sym[s]]++;
    end
    first_code[0] = 0;
    first_slot[0] = 0;
    first_code[1] = 0;
    first_slot[1] = 0;
    for (int l = 2; l < LEN_SLOTS; l++) begin
      first_code[l] = ((first_code[l-1] + len_count[l-1]) << 1) & 16'hFFFF;
      first_slot[l] = (first_slot[l-1] + len_count[l-1]) & 16'hFFFF;
    end
    for (int l = 0; l < LEN_SLOTS; l++) next_slot[l] = first_slot[l];
    for (int s = 0; s < n; s++) begin
      if (len_of_sym[s] != 0) begin
        k = next_slot[len_of_sym[s]];
        if (k < NUM_SYMS) sym_by_code[k] = s[8:0];
        next_slot[len_of_sym[s]]++;
      end
    end
    have_table = 1'b1;
    tables_built++;
  endfunction

  function automatic bit decode_step(chd_in_t r, output chd_out_t res);
    int unsigned l;
    int unsigned off;
    int unsigned k;
    res = '0;
    if (r.cmd != CMD_DECODE) begin
      code_acc = 0;
      acc_bits = 0;
      if (r.cmd == CMD_LOAD) begin
        if (r.symbol_index < NUM_SYMS) len_of_sym[r.symbol_index] = r.code_length;
        if (r.last_length) build_canonical(r.symbol_index + 1);
      end else if (r.cmd == CMD_FIXLIT) begin
        for (int s = 0; s < LIT_SYMBOLS; s++) begin
          if (s <= 143 || s >= 280) len_of_sym[s] = 4'd8;
          else if (s <= 255) len_of_sym[s] = 4'd9;
          else len_of_sym[s] = 4'd7;
        end
        build_canonical(LIT_SYMBOLS);
      end else begin
        for (int s = 0; s < DIST_SYMBOLS; s++) len_of_sym[s] = 4'd5;
        build_canonical(DIST_SYMBOLS);
      end
      return 1'b0;
    end
    if (!have_table) begin
      res = mk_res(0, 0, 1'b1);
      return 1'b1;
    end
    code_acc = ((code_acc << 1) | r.bit_in) & 16'hFFFF;
    acc_bits++;
    l = acc_bits;
    if (l < LEN_SLOTS && code_acc >= first_code[l]) begin
      off = code_acc - first_code[l];
      if (off < len_count[l]) begin
        k = first_slot[l] + off;
        res = mk_res((k < NUM_SYMS) ? int'(sym_by_code[k]) : 0, l, 1'b0);
        code_acc = 0;
        acc_bits = 0;
        return 1'b1;
      end
    end
    if (acc_bits >= CODE_MAX) begin
      res = mk_res(0, CODE_MAX, 1'b1);
      code_acc = 0;
      acc_bits = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // offers one request, waits for it to be taken, records what it should yield
  task automatic send_req(chd_in_t r, bit typed, chd_out_t typed_res);
    chd_out_t p;
    bit has;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = r;
    do @(posedge clk); while (in_stall);
    has = decode_step(r, p);
    if (typed) symbol_q.insert(symbol_q.size(), typed_res);
    else if (has) symbol_q.insert(symbol_q.size(), p);
    reqs_sent++;
    @(negedge clk);
  endtask

  task automatic send_plain(chd_in_t r);
    send_req(r, 1'b0, '0);
  endtask

  task automatic send_bit(bit b);
    send_plain(mk_req(CMD_DECODE, $urandom_range(0, 511), $urandom_range(0, 15),
                      1'($urandom_range(0, 1)), b));
  endtask

  // random lengths for symbols 0..n-1, mostly short codes
  task automatic load_lengths(int n);
    int len;
    int pick;
    for (int s = 0; s < n; s++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) len = 0;
      else if (pick == 9) len = $urandom_range(7, 15);
      else len = $urandom_range(1, 6);
      send_plain(mk_req(CMD_LOAD, s, len, s == n - 1, 1'($urandom_range(0, 1))));
    end
  endtask

  // sends the code of one randomly picked symbol, msb first
  task automatic send_codeword();
    int lens_used[$];
    int l;
    int unsigned code;
    for (int i = 1; i < LEN_SLOTS; i++) begin
      if (len_count[i] != 0) lens_used.insert(lens_used.size(), i);
    end
    if (lens_used.size() == 0) begin
      send_bit(1'($urandom_range(0, 1)));
    end else begin
      l = lens_used[$urandom_range(0, lens_used.size() - 1)];
      code = first_code[l] + $urandom_range(0, len_count[l] - 1);
      for (int i = l - 1; i >= 0; i--) send_bit(code[i]);
    end
  endtask

  typedef struct {
    chd_in_t req;
    int reps;
    bit typed;
    chd_out_t res;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic plan_row_t row(chd_in_t r, int reps, bit typed, chd_out_t res);
    plan_row_t p;
    p.req = r;
    p.reps = reps;
    p.typed = typed;
    p.res = res;
    return p;
  endfunction

  function automatic void add_row(plan_row_t p);
    plan.insert(plan.size(), p);
  endfunction

  // result checking
  always @(posedge clk) begin
    chd_out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.error) error_results++;
      if (symbol_q.size() == 0) begin
        $error("unexpected result symbol=%0d code_bits=%0d error=%0d",
               out_data.symbol, out_data.code_bits, out_data.error);
        fails++;
      end else begin
        exp_res = symbol_q.pop_front();
        if (out_data.symbol !== exp_res.symbol) begin
          $error("symbol: expected %0d, got %0d", exp_res.symbol, out_data.symbol);
          fails++;
        end
        if (out_data.code_bits !== exp_res.code_bits) begin
          $error("code_bits: expected %0d, got %0d", exp_res.code_bits, out_data.code_bits);
          fails++;
        end
        if (out_data.error !== exp_res.error) begin
          $error("error: expected %0d, got %0d", exp_res.error, out_data.error);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", symbol_q.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side stalls
  initial begin
    int burst;
    int hold;
    burst = 0;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        out_stall = 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(0, 5);
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    int pick;
    int n;
    int settle;
    bit held;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    held = 1'b0;
    fails = 0;
    reqs_sent = 0;
    results_seen = 0;
    tables_built = 0;
    error_results = 0;
    idle_cycles = 0;
    code_acc = 0;
    acc_bits = 0;
    have_table = 1'b0;
    for (int l = 0; l < LEN_SLOTS; l++) begin
      len_count[l] = 0;
      first_code[l] = 0;
      first_slot[l] = 0;
    end
    for (int s = 0; s < NUM_SYMS; s++) begin
      len_of_sym[s] = '0;
      sym_by_code[s] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // no table yet, then the fixed tables, a one-code table and big indexes
    add_row(row(mk_req(CMD_DECODE, 0, 0, 0, 1), 1, 1, mk_res(0, 0, 1)));
    add_row(row(mk_req(CMD_LOAD, 5, 3, 0, 0), 1, 0, '0));
    add_row(row(mk_req(CMD_DECODE, 511, 15, 1, 0), 1, 1, mk_res(0, 0, 1)));
    add_row(row(mk_req(CMD_FIXLIT, 0, 0, 0, 0), 1, 0, '0));
    add_row(row(mk_req(CMD_DECODE, 0, 0, 0, 0), 7, 1, mk_res(256, 7, 0)));
    add_row(row(mk_req(CMD_DECODE, 0, 0, 0, 1), 9, 1, mk_res(255, 9, 0)));
    add_row(row(mk_req(CMD_FIXDIST, 511, 15, 1, 1), 1, 0, '0));
    add_row(row(mk_req(CMD_DECODE, 0, 0, 0, 1), 5, 1, mk_res(31, 5, 0)));
    add_row(row(mk_req(CMD_DECODE, 0, 0, 0, 0), 5, 1, mk_res(0, 5, 0)));
    add_row(row(mk_req(CMD_LOAD, 0, 1, 0, 0), 1, 0, '0));
    add_row(row(mk_req(CMD_LOAD, 1, 0, 1, 0), 1, 0, '0));
    add_row(row(mk_req(CMD_DECODE, 0, 0, 0, 0), 1, 1, mk_res(0, 1, 0)));
    add_row(row(mk_req(CMD_DECODE, 0, 0, 0, 1), 15, 1, mk_res(0, 15, 1)));
    add_row(row(mk_req(CMD_LOAD, 511, 15, 1, 0), 1, 0, '0));
    add_row(row(mk_req(CMD_DECODE, 0, 0, 0, 1), 3, 0, '0));
    add_row(row(mk_req(CMD_LOAD, 287, 15, 1, 1), 1, 0, '0));
    add_row(row(mk_req(CMD_DECODE, 0, 0, 0, 0), 4, 0, '0));
    add_row(row(mk_req(CMD_FIXLIT, 300, 7, 1, 1), 1, 0, '0));
    foreach (plan[i]) begin
      for (int r = 0; r < plan[i].reps; r++) begin
        send_req(plan[i].req, plan[i].typed && r == plan[i].reps - 1, plan[i].res);
      end
    end

    // every length entry is written by now, so any alphabet may be built
    while (reqs_sent < 850) begin
      if (reqs_sent > 780) calm = 1'b1;
      if (!held && reqs_sent > 300) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_plain(mk_req(CMD_FIXLIT, $urandom_range(0, 511), $urandom_range(0, 15),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      end else if (pick < 24) begin
        send_plain(mk_req(CMD_FIXDIST, $urandom_range(0, 511), $urandom_range(0, 15),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      end else if (pick < 27) begin
        send_plain(mk_req(CMD_LOAD, $urandom_range(NUM_SYMS, 511), $urandom_range(0, 15),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      end else if (pick < 29 && reqs_sent < 550) begin
        load_lengths(NUM_SYMS);
      end else if (pick < 55) begin
        n = $urandom_range(2, 24);
        load_lengths(n);
      end else if (pick < 60) begin
        // partial rewrite of the current lengths, built or not
        send_plain(mk_req(CMD_LOAD, $urandom_range(0, NUM_SYMS - 1), $urandom_range(0, 15),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      end else if (pick < 68) begin
        repeat ($urandom_range(1, 20)) send_bit(1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(3, 12)) send_codeword();
      end
    end
    in_valid = 1'b0;
    calm = 1'b1;

    while (symbol_q.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 50) begin
      @(posedge clk);
      settle++;
    end
    $display("%0d requests sent, %0d tables built, %0d results checked (%0d errors flagged)",
             reqs_sent, tables_built, results_seen, error_results);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
